// ===== src/mdgis_pkg.sv =====
// Shared types and constants for the min-degree greedy independent set block.
// Holds the item and result layouts, mode and register codes, and the
// controller/datapath command and status structs. No dependencies.
package mdgis_pkg;

    localparam int VERTEX_W = 10;
    localparam int MODE_W = 2;
    localparam int COUNT_W = 11;
    localparam int SEED_W = 64;
    localparam int CFG_IDX_W = 1;
    localparam int DRAW_W = 32;
    localparam int SHIFT_LEFT = 7;
    localparam int SHIFT_RIGHT = 9;

    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EDGE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 1'd1;

    localparam logic [COUNT_W-1:0] VCOUNT_RESET = 11'd1024;
    localparam logic [SEED_W-1:0] SEED_RESET = 64'd88172645463325252;

    localparam logic ANS_RUN = 1'b0;
    localparam logic ANS_READ = 1'b1;

    localparam logic [1:0] KIND_DEG = 2'd0;
    localparam logic [1:0] KIND_PICK = 2'd1;
    localparam logic [1:0] KIND_RM = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [VERTEX_W-1:0] first_vertex;
        logic [VERTEX_W-1:0] second_vertex;
    } item_t;

    typedef struct packed {
        logic                answer_kind;
        logic [COUNT_W-1:0]  set_size;
        logic [VERTEX_W-1:0] queried_vertex;
        logic                is_selected;
    } result_t;

    typedef struct packed {
        logic accept;
        logic clr_write;
        logic edge_rd1;
        logic edge_wr1;
        logic edge_wr2;
        logic out_read;
        logic out_run;
        logic run_init;
        logic deg_start;
        logic deg_issue;
        logic mod_start;
        logic mod_step;
        logic pick_issue;
        logic take;
        logic rm_issue;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic edge_ok;
        logic deg_done;
        logic best_valid;
        logic mod_done;
        logic found;
        logic rm_done;
        logic out_free;
    } sts_t;

endpackage

// ===== src/min_degree_greedy_independent_set_core.sv =====
// Min-degree greedy maximal independent set core; one item at a time.
// Edge item: both matrix words are updated unless the edge is rejected; clear: DEPTH words written,
// DEPTH = MAX_VERTICES * ceil(MAX_VERTICES / WORD_BITS), one matrix word written per cycle.
// Run item: the time taken per chosen vertex is set by the single
// adjacency read port and the bit-serial modulo unit. Reset is asynchronous, active low;
// after it the core sweeps the adjacency memory to zero before taking items.
module min_degree_greedy_independent_set_core #(
    parameter int MAX_VERTICES = 1024,
    parameter int WORD_BITS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  mdgis_pkg::item_t                item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output mdgis_pkg::result_t              result,
    input  logic                            cfg_write,
    input  logic [mdgis_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mdgis_pkg::SEED_W-1:0]    cfg_data
);

    mdgis_pkg::cmd_t cmd;
    mdgis_pkg::sts_t sts;

    mdgis_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_mode  (item.mode),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    mdgis_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .WORD_BITS    (WORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

    // A random draw is only started when some vertex is still remaining.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.mod_start |-> sts.best_valid)
        else $error("draw started with no candidate");

    // The core takes one item and then works on it before taking another.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("second item taken while busy");

    // No matrix clearing or scanning while the core sits ready for an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> (!cmd.clr_write && !cmd.deg_issue && !cmd.rm_issue))
        else $error("datapath active while idle");

    // A take always follows a found pick.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.take |-> sts.found)
        else $error("vertex taken without a pick");

endmodule

// ===== src/mdgis_ctrl.sv =====
// Sequencing state machine for the independent set block.
// Depends on mdgis_pkg for the command and status structs and mode codes.
module mdgis_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic [mdgis_pkg::MODE_W-1:0]  item_mode,
    output logic                          item_ready,
    input  mdgis_pkg::sts_t               sts,
    output mdgis_pkg::cmd_t               cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_E_RD1 = 4'd2;
    localparam logic [3:0] S_E_WR1 = 4'd3;
    localparam logic [3:0] S_E_WR2 = 4'd4;
    localparam logic [3:0] S_READ  = 4'd5;
    localparam logic [3:0] S_INIT  = 4'd6;
    localparam logic [3:0] S_DEG   = 4'd7;
    localparam logic [3:0] S_CHECK = 4'd8;
    localparam logic [3:0] S_MOD   = 4'd9;
    localparam logic [3:0] S_PICK  = 4'd10;
    localparam logic [3:0] S_TAKE  = 4'd11;
    localparam logic [3:0] S_RM    = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    case (item_mode)
                        mdgis_pkg::MODE_CLEAR: state_next = S_CLEAR;
                        mdgis_pkg::MODE_EDGE:  state_next = S_E_RD1;
                        mdgis_pkg::MODE_RUN:   state_next = S_INIT;
                        mdgis_pkg::MODE_READ:  state_next = S_READ;
                        default:               state_next = S_IDLE;
                    endcase
                end
            end
            S_E_RD1:
            begin
                // Self loops and out-of-range endpoints leave the matrix alone.
                if (sts.edge_ok)
                begin
                    cmd.edge_rd1 = 1'b1;
                    state_next = S_E_WR1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_E_WR1:
            begin
                cmd.edge_wr1 = 1'b1;
                state_next = S_E_WR2;
            end
            S_E_WR2:
            begin
                cmd.edge_wr2 = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                if (sts.out_free)
                begin
                    cmd.out_read = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_INIT:
            begin
                cmd.run_init = 1'b1;
                cmd.deg_start = 1'b1;
                state_next = S_DEG;
            end
            S_DEG:
            begin
                cmd.deg_issue = 1'b1;
                if (sts.deg_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.best_valid)
                begin
                    cmd.mod_start = 1'b1;
                    state_next = S_MOD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_done)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.pick_issue = 1'b1;
                if (sts.found)
                begin
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                cmd.take = 1'b1;
                state_next = S_RM;
            end
            S_RM:
            begin
                cmd.rm_issue = 1'b1;
                if (sts.rm_done)
                begin
                    cmd.deg_start = 1'b1;
                    state_next = S_DEG;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_run = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/mdgis_dp.sv =====
// Datapath of the independent set block: adjacency and degree memories,
// vertex masks, scan pipeline, xorshift generator, modulo unit and result register.
// Depends on mdgis_pkg; driven by mdgis_ctrl through cmd_t and sts_t.
module mdgis_dp #(
    parameter int MAX_VERTICES = 1024,
    parameter int WORD_BITS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [mdgis_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mdgis_pkg::SEED_W-1:0]      cfg_data,
    input  mdgis_pkg::item_t                  item,
    input  mdgis_pkg::cmd_t                   cmd,
    output mdgis_pkg::sts_t                   sts,
    input  logic                              result_ready,
    output logic                              result_valid,
    output mdgis_pkg::result_t                result
);

    localparam int WORDS = (MAX_VERTICES + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH = MAX_VERTICES * WORDS;
    localparam int AW = $clog2(DEPTH);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int PADW = WORDS * WORD_BITS;
    localparam int WIW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WCW = $clog2(WORDS + 1);
    localparam int PCW = $clog2(WORD_BITS + 1);
    localparam int CHUNKS = (WORD_BITS + 7) / 8;
    localparam int XW = (VW > mdgis_pkg::VERTEX_W) ? VW : mdgis_pkg::VERTEX_W;
    localparam int SH = mdgis_pkg::VERTEX_W + 8;
    localparam int PW = mdgis_pkg::VERTEX_W + SH;
    localparam int RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int MSW = $clog2(mdgis_pkg::DRAW_W + 1);

    // Word index of a vertex by reciprocal multiplication; exact for 10-bit vertices.
    function automatic logic [mdgis_pkg::VERTEX_W-1:0] word_of(
        input logic [mdgis_pkg::VERTEX_W-1:0] v);
        logic [PW-1:0] p;
        p = PW'(v) * PW'(RECIP);
        return mdgis_pkg::VERTEX_W'(p >> SH);
    endfunction

    function automatic logic [WORD_BITS-1:0] bit_mask(
        input logic [mdgis_pkg::VERTEX_W-1:0] v);
        logic [mdgis_pkg::VERTEX_W-1:0] q;
        logic [mdgis_pkg::VERTEX_W-1:0] r;
        q = word_of(v);
        r = mdgis_pkg::VERTEX_W'(32'(v) - 32'(q) * WORD_BITS);
        return WORD_BITS'(1) << r;
    endfunction

    function automatic logic [PCW-1:0] pop_word(input logic [WORD_BITS-1:0] x);
        logic [CHUNKS*8-1:0] xp;
        logic [3:0] part [CHUNKS];
        logic [PCW-1:0] s;
        xp = (CHUNKS*8)'(x);
        s = '0;
        for (int c = 0; c < CHUNKS; c++)
        begin
            part[c] = '0;
            for (int k = 0; k < 8; k++)
            begin
                part[c] = part[c] + 4'(xp[c*8+k]);
            end
        end
        for (int c = 0; c < CHUNKS; c++)
        begin
            s = s + PCW'(part[c]);
        end
        return s;
    endfunction

    // Configuration and item registers.
    logic [mdgis_pkg::COUNT_W-1:0] vcount_reg;
    logic [mdgis_pkg::SEED_W-1:0]  seed_reg;
    mdgis_pkg::item_t              item_reg;

    // Memories.
    logic [WORD_BITS-1:0] adj_mem [DEPTH];
    logic [WORD_BITS-1:0] adj_rd_reg;
    logic [VW-1:0]        deg_mem [MAX_VERTICES];
    logic [VW-1:0]        deg_rd_reg;

    logic                 adj_we;
    logic [AW-1:0]        adj_waddr;
    logic [WORD_BITS-1:0] adj_wdata;
    logic [AW-1:0]        adj_raddr;
    logic                 deg_we;
    logic [VW-1:0]        deg_waddr;
    logic [VW-1:0]        deg_wdata;

    // Run state.
    logic [PADW-1:0] rem_reg, rem_next;
    logic [PADW-1:0] chosen_reg, chosen_next;
    logic [NW-1:0]   cnt_reg, cnt_next;
    logic [mdgis_pkg::SEED_W-1:0] rng_reg, rng_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [NW-1:0]   vtx_reg, vtx_next;
    logic [WCW-1:0]  word_reg, word_next;

    logic            p1_v_reg, p1_v_next;
    logic [1:0]      p1_kind_reg, p1_kind_next;
    logic [VW-1:0]   p1_vtx_reg, p1_vtx_next;
    logic [WIW-1:0]  p1_word_reg, p1_word_next;
    logic            p2_v_reg, p2_v_next;
    logic [VW-1:0]   p2_vtx_reg, p2_vtx_next;
    logic [WIW-1:0]  p2_word_reg, p2_word_next;
    logic [PCW-1:0]  pc_reg, pc_next;
    logic [VW-1:0]   acc_reg, acc_next;

    logic [VW-1:0]   best_reg, best_next;
    logic            best_v_reg, best_v_next;
    logic [NW-1:0]   cands_reg, cands_next;

    logic [mdgis_pkg::DRAW_W-1:0] div_reg, div_next;
    logic [NW-1:0]   rmd_reg, rmd_next;
    logic [MSW-1:0]  mstep_reg, mstep_next;
    logic [NW-1:0]   seen_reg, seen_next;
    logic            found_reg, found_next;
    logic [VW-1:0]   pick_v_reg, pick_v_next;

    mdgis_pkg::result_t res_reg, res_next;
    logic               res_valid_reg, res_valid_next;

    // Derived values.
    logic [NW-1:0]   n;
    logic            edge_ok;
    logic [AW-1:0]   edge_addr1;
    logic [AW-1:0]   edge_addr2;
    logic            deg_go;
    logic            pick_go;
    logic            rm_go;
    logic [XW-1:0]   a_x;
    logic            read_sel;

    always_comb
    begin
        if (32'(vcount_reg) > MAX_VERTICES)
        begin
            n = NW'(MAX_VERTICES);
        end
        else
        begin
            n = NW'(vcount_reg);
        end
    end

    assign edge_ok = (32'(item_reg.first_vertex) < 32'(n))
                  && (32'(item_reg.second_vertex) < 32'(n))
                  && (item_reg.first_vertex != item_reg.second_vertex);
    assign edge_addr1 = AW'(32'(item_reg.first_vertex) * WORDS
                          + 32'(word_of(item_reg.second_vertex)));
    assign edge_addr2 = AW'(32'(item_reg.second_vertex) * WORDS
                          + 32'(word_of(item_reg.first_vertex)));

    assign deg_go = cmd.deg_issue && (vtx_reg < n);
    assign pick_go = cmd.pick_issue && (vtx_reg < n) && !found_reg;
    assign rm_go = cmd.rm_issue && (32'(word_reg) < WORDS);

    assign a_x = XW'(item_reg.first_vertex);
    assign read_sel = (32'(item_reg.first_vertex) < MAX_VERTICES) && chosen_reg[a_x[VW-1:0]];

    // Memory port selection.
    always_comb
    begin
        adj_we = 1'b0;
        adj_waddr = clr_reg;
        adj_wdata = '0;
        if (cmd.clr_write)
        begin
            adj_we = 1'b1;
        end
        else if (cmd.edge_wr1)
        begin
            adj_we = 1'b1;
            adj_waddr = edge_addr1;
            adj_wdata = adj_rd_reg | bit_mask(item_reg.second_vertex);
        end
        else if (cmd.edge_wr2)
        begin
            adj_we = 1'b1;
            adj_waddr = edge_addr2;
            adj_wdata = adj_rd_reg | bit_mask(item_reg.first_vertex);
        end

        if (cmd.edge_rd1)
        begin
            adj_raddr = edge_addr1;
        end
        else if (cmd.edge_wr1)
        begin
            adj_raddr = edge_addr2;
        end
        else if (cmd.rm_issue)
        begin
            adj_raddr = AW'(32'(pick_v_reg) * WORDS + 32'(word_reg));
        end
        else
        begin
            adj_raddr = AW'(32'(vtx_reg) * WORDS + 32'(word_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        adj_rd_reg <= adj_mem[adj_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        deg_rd_reg <= deg_mem[vtx_reg[VW-1:0]];
    end

    // Next-state logic for the run datapath.
    always_comb
    begin
        logic [VW-1:0] d;
        logic [NW:0]   t;
        logic [mdgis_pkg::SEED_W-1:0] y;
        logic [mdgis_pkg::SEED_W-1:0] z;

        rem_next = rem_reg;
        chosen_next = chosen_reg;
        cnt_next = cnt_reg;
        rng_next = rng_reg;
        clr_next = clr_reg;
        vtx_next = vtx_reg;
        word_next = word_reg;
        p1_v_next = 1'b0;
        p1_kind_next = p1_kind_reg;
        p1_vtx_next = p1_vtx_reg;
        p1_word_next = p1_word_reg;
        p2_v_next = 1'b0;
        p2_vtx_next = p2_vtx_reg;
        p2_word_next = p2_word_reg;
        pc_next = pc_reg;
        acc_next = acc_reg;
        best_next = best_reg;
        best_v_next = best_v_reg;
        cands_next = cands_reg;
        div_next = div_reg;
        rmd_next = rmd_reg;
        mstep_next = mstep_reg;
        seen_next = seen_reg;
        found_next = found_reg;
        pick_v_next = pick_v_reg;
        deg_we = 1'b0;
        deg_waddr = p2_vtx_reg;
        d = VW'(((p2_word_reg == '0) ? 32'(0) : 32'(acc_reg)) + 32'(pc_reg));
        deg_wdata = d;
        t = {rmd_reg, div_reg[mdgis_pkg::DRAW_W-1]};
        y = rng_reg ^ (rng_reg << mdgis_pkg::SHIFT_LEFT);
        z = y ^ (y >> mdgis_pkg::SHIFT_RIGHT);

        if (cmd.accept)
        begin
            clr_next = '0;
        end
        else if (cmd.clr_write)
        begin
            clr_next = clr_reg + AW'(1);
        end

        if (cmd.run_init)
        begin
            for (int i = 0; i < PADW; i++)
            begin
                rem_next[i] = (32'(i) < 32'(n));
            end
            chosen_next = '0;
            cnt_next = '0;
            rng_next = seed_reg;
        end

        if (cmd.deg_start)
        begin
            vtx_next = '0;
            word_next = '0;
            best_v_next = 1'b0;
            cands_next = '0;
        end

        // Issue stage of the three scans.
        if (deg_go)
        begin
            p1_v_next = 1'b1;
            p1_kind_next = mdgis_pkg::KIND_DEG;
            p1_vtx_next = vtx_reg[VW-1:0];
            p1_word_next = word_reg[WIW-1:0];
            if (32'(word_reg) == WORDS - 1)
            begin
                word_next = '0;
                vtx_next = vtx_reg + NW'(1);
            end
            else
            begin
                word_next = word_reg + WCW'(1);
            end
        end
        if (pick_go)
        begin
            p1_v_next = 1'b1;
            p1_kind_next = mdgis_pkg::KIND_PICK;
            p1_vtx_next = vtx_reg[VW-1:0];
            vtx_next = vtx_reg + NW'(1);
        end
        if (rm_go)
        begin
            p1_v_next = 1'b1;
            p1_kind_next = mdgis_pkg::KIND_RM;
            p1_word_next = word_reg[WIW-1:0];
            word_next = word_reg + WCW'(1);
        end

        // Data stage: memory word is in adj_rd_reg or deg_rd_reg.
        if (p1_v_reg)
        begin
            case (p1_kind_reg)
                mdgis_pkg::KIND_DEG:
                begin
                    p2_v_next = 1'b1;
                    p2_vtx_next = p1_vtx_reg;
                    p2_word_next = p1_word_reg;
                    pc_next = pop_word(adj_rd_reg
                              & rem_reg[p1_word_reg*WORD_BITS +: WORD_BITS]);
                end
                mdgis_pkg::KIND_PICK:
                begin
                    if (!found_reg && rem_reg[p1_vtx_reg] && (deg_rd_reg == best_reg))
                    begin
                        if (seen_reg == rmd_reg)
                        begin
                            found_next = 1'b1;
                            pick_v_next = p1_vtx_reg;
                        end
                        else
                        begin
                            seen_next = seen_reg + NW'(1);
                        end
                    end
                end
                mdgis_pkg::KIND_RM:
                begin
                    rem_next[p1_word_reg*WORD_BITS +: WORD_BITS] =
                        rem_reg[p1_word_reg*WORD_BITS +: WORD_BITS] & ~adj_rd_reg;
                end
                default:
                begin
                end
            endcase
        end

        // Accumulate stage of the degree scan.
        if (p2_v_reg)
        begin
            acc_next = d;
            if ((32'(p2_word_reg) == WORDS - 1) && rem_reg[p2_vtx_reg])
            begin
                deg_we = 1'b1;
                if (!best_v_reg || (d < best_reg))
                begin
                    best_next = d;
                    best_v_next = 1'b1;
                    cands_next = NW'(1);
                end
                else if (d == best_reg)
                begin
                    cands_next = cands_reg + NW'(1);
                end
            end
        end

        // Draw and reduce modulo the candidate count, one quotient bit a cycle.
        if (cmd.mod_start)
        begin
            rng_next = z;
            div_next = z[mdgis_pkg::DRAW_W-1:0];
            rmd_next = '0;
            mstep_next = '0;
            vtx_next = '0;
            seen_next = '0;
            found_next = 1'b0;
        end
        else if (cmd.mod_step && (32'(mstep_reg) < mdgis_pkg::DRAW_W))
        begin
            if (t >= (NW+1)'(cands_reg))
            begin
                rmd_next = NW'(t - (NW+1)'(cands_reg));
            end
            else
            begin
                rmd_next = NW'(t);
            end
            div_next = div_reg << 1;
            mstep_next = mstep_reg + MSW'(1);
        end

        if (cmd.take)
        begin
            chosen_next[pick_v_reg] = 1'b1;
            rem_next[pick_v_reg] = 1'b0;
            cnt_next = cnt_reg + NW'(1);
            word_next = '0;
        end
    end

    // Result register.
    always_comb
    begin
        res_next = res_reg;
        res_valid_next = res_valid_reg;
        if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (cmd.out_read)
        begin
            res_valid_next = 1'b1;
            res_next.answer_kind = mdgis_pkg::ANS_READ;
            res_next.set_size = mdgis_pkg::COUNT_W'(cnt_reg);
            res_next.queried_vertex = item_reg.first_vertex;
            res_next.is_selected = read_sel;
        end
        else if (cmd.out_run)
        begin
            res_valid_next = 1'b1;
            res_next.answer_kind = mdgis_pkg::ANS_RUN;
            res_next.set_size = mdgis_pkg::COUNT_W'(cnt_reg);
            res_next.queried_vertex = '0;
            res_next.is_selected = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= mdgis_pkg::VCOUNT_RESET;
            seed_reg <= mdgis_pkg::SEED_RESET;
            rem_reg <= '0;
            chosen_reg <= '0;
            cnt_reg <= '0;
            rng_reg <= mdgis_pkg::SEED_RESET;
            clr_reg <= '0;
            vtx_reg <= '0;
            word_reg <= '0;
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            best_v_reg <= 1'b0;
            cands_reg <= '0;
            mstep_reg <= '0;
            seen_reg <= '0;
            found_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    mdgis_pkg::CFG_VERTEX_COUNT:
                        vcount_reg <= cfg_data[mdgis_pkg::COUNT_W-1:0];
                    mdgis_pkg::CFG_RANDOM_SEED:
                        seed_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            rem_reg <= rem_next;
            chosen_reg <= chosen_next;
            cnt_reg <= cnt_next;
            rng_reg <= rng_next;
            clr_reg <= clr_next;
            vtx_reg <= vtx_next;
            word_reg <= word_next;
            p1_v_reg <= p1_v_next;
            p2_v_reg <= p2_v_next;
            best_v_reg <= best_v_next;
            cands_reg <= cands_next;
            mstep_reg <= mstep_next;
            seen_reg <= seen_next;
            found_reg <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= item;
        end
        p1_kind_reg <= p1_kind_next;
        p1_vtx_reg <= p1_vtx_next;
        p1_word_reg <= p1_word_next;
        p2_vtx_reg <= p2_vtx_next;
        p2_word_reg <= p2_word_next;
        pc_reg <= pc_next;
        acc_reg <= acc_next;
        best_reg <= best_next;
        div_reg <= div_next;
        rmd_reg <= rmd_next;
        pick_v_reg <= pick_v_next;
        res_reg <= res_next;
    end

    assign sts.clr_last = (32'(clr_reg) == DEPTH - 1);
    assign sts.edge_ok = edge_ok;
    assign sts.deg_done = !(vtx_reg < n) && !p1_v_reg && !p2_v_reg;
    assign sts.best_valid = best_v_reg;
    assign sts.mod_done = (32'(mstep_reg) == mdgis_pkg::DRAW_W);
    assign sts.found = found_reg;
    assign sts.rm_done = !(32'(word_reg) < WORDS) && !p1_v_reg;
    assign sts.out_free = !res_valid_reg || result_ready;

    assign result_valid = res_valid_reg;
    assign result = res_reg;

endmodule

// ===== bench/min_degree_greedy_independent_set_core_tb.sv =====
// Testbench for min_degree_greedy_independent_set_core: graph loading, greedy runs and reads,
// checked against a predictor of the greedy choice. Depends on mdgis_pkg and the core RTL.
`timescale 1ns / 100ps

module min_degree_greedy_independent_set_core_tb;

    localparam int MAX_V = 1024;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    mdgis_pkg::item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    mdgis_pkg::result_t result;
    logic cfg_write = 1'b0;
    logic [mdgis_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mdgis_pkg::SEED_W-1:0] cfg_data = '0;

    min_degree_greedy_independent_set_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Predictor state.
    bit [MAX_V-1:0] adj_rows [MAX_V];
    bit [MAX_V-1:0] chosen_set;
    int unsigned chosen_total;
    int unsigned vcount_reg = 1024;
    bit [63:0] seed_reg = mdgis_pkg::SEED_RESET;

    mdgis_pkg::item_t pending_items [$];
    mdgis_pkg::result_t expected_answers [$];
    int error_count = 0;
    logic took_item = 1'b0;

    function automatic int unsigned live_vertices();
        return (vcount_reg > MAX_V) ? MAX_V : vcount_reg;
    endfunction

    function automatic void solve_independent_set();
        int unsigned n;
        int unsigned best;
        int unsigned cands;
        int unsigned pick;
        int unsigned seen;
        int unsigned v;
        int unsigned deg [MAX_V];
        bit [MAX_V-1:0] remaining;
        bit [63:0] gen;
        bit running;
        n = live_vertices();
        remaining = '0;
        for (int i = 0; i < n; i++)
            remaining[i] = 1'b1;
        chosen_set = '0;
        chosen_total = 0;
        gen = seed_reg;
        running = 1'b1;
        while (running)
        begin
            best = 32'hFFFF_FFFF;
            for (int i = 0; i < n; i++)
            begin
                if (remaining[i])
                begin
                    deg[i] = $countones(adj_rows[i] & remaining);
                    if (deg[i] < best)
                        best = deg[i];
                end
            end
            if (best == 32'hFFFF_FFFF)
                running = 1'b0;
            else
            begin
                cands = 0;
                for (int i = 0; i < n; i++)
                    if (remaining[i] && deg[i] == best)
                        cands++;
                gen ^= gen << mdgis_pkg::SHIFT_LEFT;
                gen ^= gen >> mdgis_pkg::SHIFT_RIGHT;
                pick = gen[31:0] % cands;
                seen = 0;
                v = 0;
                for (int i = 0; i < n; i++)
                begin
                    if (remaining[i] && deg[i] == best)
                    begin
                        if (seen == pick)
                        begin
                            v = i;
                            break;
                        end
                        seen++;
                    end
                end
                chosen_set[v] = 1'b1;
                chosen_total++;
                remaining[v] = 1'b0;
                remaining &= ~adj_rows[v];
            end
        end
    endfunction

    function automatic void predict_answer(mdgis_pkg::item_t it);
        int unsigned n;
        mdgis_pkg::result_t ans;
        n = live_vertices();
        ans = '0;
        case (it.mode)
            mdgis_pkg::MODE_CLEAR:
                for (int i = 0; i < MAX_V; i++)
                    adj_rows[i] = '0;
            mdgis_pkg::MODE_EDGE:
                if (it.first_vertex < n && it.second_vertex < n
                    && it.first_vertex != it.second_vertex)
                begin
                    adj_rows[it.first_vertex][it.second_vertex] = 1'b1;
                    adj_rows[it.second_vertex][it.first_vertex] = 1'b1;
                end
            mdgis_pkg::MODE_RUN:
            begin
                solve_independent_set();
                ans.answer_kind = mdgis_pkg::ANS_RUN;
                ans.set_size = chosen_total[mdgis_pkg::COUNT_W-1:0];
                expected_answers.insert(expected_answers.size(), ans);
            end
            default:
            begin
                ans.answer_kind = mdgis_pkg::ANS_READ;
                ans.set_size = chosen_total[mdgis_pkg::COUNT_W-1:0];
                ans.queried_vertex = it.first_vertex;
                ans.is_selected = chosen_set[it.first_vertex];
                expected_answers.insert(expected_answers.size(), ans);
            end
        endcase
    endfunction

    task automatic check_answer(mdgis_pkg::result_t got);
        mdgis_pkg::result_t want;
        if (expected_answers.size() == 0)
        begin
            $error("unexpected result item: %p", got);
            error_count++;
        end
        else
        begin
            want = expected_answers.pop_front();
            if (got.answer_kind !== want.answer_kind)
            begin
                $error("answer_kind: expected %0d, actual %0d", want.answer_kind,
                    got.answer_kind);
                error_count++;
            end
            if (got.set_size !== want.set_size)
            begin
                $error("set_size: expected %0d, actual %0d", want.set_size, got.set_size);
                error_count++;
            end
            if (got.queried_vertex !== want.queried_vertex)
            begin
                $error("queried_vertex: expected %0d, actual %0d", want.queried_vertex,
                    got.queried_vertex);
                error_count++;
            end
            if (got.is_selected !== want.is_selected)
            begin
                $error("is_selected: expected %0d, actual %0d", want.is_selected,
                    got.is_selected);
                error_count++;
            end
        end
    endtask

    // Results are checked before the new item is predicted, since the core works on one
    // item at a time.
    always @(posedge clk)
    begin
        took_item <= item_valid && item_ready;
        if (rst_n)
        begin
            if (result_valid && result_ready)
                check_answer(result);
            if (item_valid && item_ready)
                predict_answer(item);
        end
    end

    int burst_left = 1;
    int gap_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!(item_valid && !took_item))
        begin
            if (gap_left > 0)
            begin
                item_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_items.size() > 0)
            begin
                item <= pending_items.pop_front();
                item_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                item_valid <= 1'b0;
        end
    end

    // The receiver switches between steady, light and heavy stalling, chosen at random.
    int ready_pct = 100;
    int stall_phase = 0;

    always @(negedge clk)
    begin
        stall_phase++;
        if (stall_phase >= 300)
        begin
            stall_phase = 0;
            case ($urandom_range(0, 2))
                0: ready_pct = 100;
                1: ready_pct = 70;
                default: ready_pct = 25;
            endcase
        end
        result_ready <= ($urandom_range(0, 99) < ready_pct);
    end

    task automatic add_item(logic [mdgis_pkg::MODE_W-1:0] m, int unsigned a, int unsigned b);
        mdgis_pkg::item_t it;
        it.mode = m;
        it.first_vertex = a[mdgis_pkg::VERTEX_W-1:0];
        it.second_vertex = b[mdgis_pkg::VERTEX_W-1:0];
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_items.size() != 0 || item_valid || expected_answers.size() != 0)
            @(negedge clk);
        // Every phase ends on a read, so the core is idle soon after its answer.
        repeat (100) @(negedge clk);
    endtask

    task automatic write_reg(logic [mdgis_pkg::CFG_IDX_W-1:0] idx, bit [63:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == mdgis_pkg::CFG_VERTEX_COUNT)
            vcount_reg = val[mdgis_pkg::COUNT_W-1:0];
        else
            seed_reg = val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic int unsigned pick_vertex(int unsigned n);
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, MAX_V - 1);
        return $urandom_range(0, n + 1);
    endfunction

    task automatic add_edges(int count, int unsigned n);
        int unsigned a;
        for (int k = 0; k < count; k++)
        begin
            a = pick_vertex(n);
            if ($urandom_range(0, 9) == 0)
                add_item(mdgis_pkg::MODE_EDGE, a, a);
            else
                add_item(mdgis_pkg::MODE_EDGE, a, pick_vertex(n));
        end
    endtask

    task automatic add_reads(int count, int unsigned n);
        for (int k = 0; k < count; k++)
            add_item(mdgis_pkg::MODE_READ,
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_V - 1)
                : $urandom_range(0, n - 1), $urandom_range(0, MAX_V - 1));
    endtask

    initial
    begin
        bit [63:0] seed_val;
        int unsigned n;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reads before any run, and edges at the top of the default vertex range.
        add_item(mdgis_pkg::MODE_READ, 0, 0);
        add_item(mdgis_pkg::MODE_READ, MAX_V - 1, 0);
        add_item(mdgis_pkg::MODE_EDGE, MAX_V - 1, 0);
        add_item(mdgis_pkg::MODE_EDGE, 0, MAX_V - 1);
        add_item(mdgis_pkg::MODE_EDGE, 7, 7);
        add_item(mdgis_pkg::MODE_EDGE, MAX_V - 1, MAX_V - 2);
        add_item(mdgis_pkg::MODE_CLEAR, 0, 0);
        add_item(mdgis_pkg::MODE_READ, MAX_V - 1, MAX_V - 1);
        wait_idle();

        // A zero vertex count chooses nothing; upper data bits are ignored.
        write_reg(mdgis_pkg::CFG_VERTEX_COUNT, {$urandom, $urandom} & ~64'h7FF);
        add_item(mdgis_pkg::MODE_EDGE, 0, 1);
        add_item(mdgis_pkg::MODE_RUN, 0, 0);
        add_item(mdgis_pkg::MODE_READ, 5, 0);
        wait_idle();

        write_reg(mdgis_pkg::CFG_VERTEX_COUNT, 64'd1);
        add_item(mdgis_pkg::MODE_EDGE, 0, 1);
        add_item(mdgis_pkg::MODE_RUN, 0, 0);
        add_item(mdgis_pkg::MODE_READ, 0, 0);
        add_item(mdgis_pkg::MODE_READ, 1, 0);
        wait_idle();

        // Zero seed always draws the first candidate.
        write_reg(mdgis_pkg::CFG_VERTEX_COUNT, 64'd3);
        write_reg(mdgis_pkg::CFG_RANDOM_SEED, 64'd0);
        add_item(mdgis_pkg::MODE_EDGE, 0, 1);
        add_item(mdgis_pkg::MODE_EDGE, 1, 2);
        add_item(mdgis_pkg::MODE_RUN, 0, 0);
        add_item(mdgis_pkg::MODE_READ, 0, 0);
        add_item(mdgis_pkg::MODE_READ, 1, 0);
        add_item(mdgis_pkg::MODE_READ, 2, 0);
        wait_idle();

        // A count above the maximum acts as the maximum.
        write_reg(mdgis_pkg::CFG_VERTEX_COUNT, 64'd2047);
        add_item(mdgis_pkg::MODE_EDGE, MAX_V - 1, 512);
        add_edges(6, MAX_V - 2);
        add_item(mdgis_pkg::MODE_READ, MAX_V - 1, 0);
        wait_idle();

        for (int ph = 0; ph < 55; ph++)
        begin
            n = $urandom_range(2, 24);
            write_reg(mdgis_pkg::CFG_VERTEX_COUNT, {$urandom, $urandom} & ~64'h7FF | n);
            case (ph % 7)
                0: seed_val = 64'd0;
                3: seed_val = '1;
                default: seed_val = {$urandom, $urandom};
            endcase
            write_reg(mdgis_pkg::CFG_RANDOM_SEED, seed_val);
            if ($urandom_range(0, 3) == 0)
                add_item(mdgis_pkg::MODE_CLEAR, $urandom_range(0, MAX_V - 1),
                    $urandom_range(0, MAX_V - 1));
            add_edges($urandom_range(6, 18), n);
            add_item(mdgis_pkg::MODE_RUN, $urandom_range(0, MAX_V - 1),
                $urandom_range(0, MAX_V - 1));
            add_reads(3, n);
            add_edges($urandom_range(2, 10), n);
            add_item(mdgis_pkg::MODE_RUN, 0, 0);
            add_reads(1, n);
            wait_idle();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
